FILE: hdl/acmt_pkg.sv
// Package for the AES-128 CBC-MAC tag engine: types, constants and AES helpers.
package acmt_pkg;

    localparam int BlockBytes = 16;
    localparam int Rounds     = 10;
    localparam int QueueDepth = 2;

    typedef enum logic {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } t_out_beat;

    // Front-to-back job: a full chain block to encrypt, plus whether it closes a message.
    typedef struct packed {
        logic [127:0] block;
        logic         last;
    } t_job;

    typedef logic [7:0] t_sbox [256];

    localparam t_sbox Sbox = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Byte k of a 128-bit word, byte 0 most significant.
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int k);
        return w[127 - 8 * k -: 8];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] next_rcon(input logic [7:0] rc);
        return gf_double(rc);
    endfunction

    // One key-schedule step: round key r from round key r-1 and rcon.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {Sbox[k[23:16]] ^ rc, Sbox[k[15:8]], Sbox[k[7:0]], Sbox[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // One cipher round; final round skips MixColumns.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic final_rnd);
        logic [7:0]   tmp [16];
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                tmp[i + 4 * c] = Sbox[get_byte(s, i + 4 * ((c + i) % 4))];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = tmp[4 * c];
            a1 = tmp[4 * c + 1];
            a2 = tmp[4 * c + 2];
            a3 = tmp[4 * c + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (final_rnd) begin
                o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[127 - 32 * c -: 32] = {a0 ^ al ^ gf_double(a0 ^ a1),
                                         a1 ^ al ^ gf_double(a1 ^ a2),
                                         a2 ^ al ^ gf_double(a2 ^ a3),
                                         a3 ^ al ^ gf_double(a3 ^ a0)};
            end
        end
        return o ^ rk;
    endfunction

endpackage

FILE: hdl/acmt_front.sv
// Front end: absorbs message bytes into a 128-bit block and issues jobs to the back end.
module acmt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  acmt_pkg::t_in_beat i_in,
    output logic             o_job_valid,
    output acmt_pkg::t_job   o_job,
    input  logic             i_job_ready
);
    import acmt_pkg::*;

    logic [127:0] r_blk, n_blk;
    logic [3:0]   r_pos;
    logic         r_job_valid;
    t_job         r_job;
    logic         w_take, w_issue;

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
    // Stall only when an issued job is still waiting and this byte would issue another.
    assign o_full = r_job_valid && !i_job_ready && ((r_pos == 4'd15) || i_in.last_byte);
    assign w_take  = i_push && !o_full;
    assign w_issue = w_take && ((r_pos == 4'd15) || i_in.last_byte);

    always_comb begin
        n_blk = r_blk;
        n_blk[127 - 8 * r_pos -: 8] = r_blk[127 - 8 * r_pos -: 8] ^ i_in.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_blk       <= '0;
            r_job_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_job_valid <= 1'b1;
            end else if (r_job_valid && i_job_ready) begin
                r_job_valid <= 1'b0;
            end
            if (w_take) begin
                if (w_issue) begin
                    r_job.block <= n_blk;
                    r_job.last  <= i_in.last_byte;
                    r_blk       <= '0;
                    r_pos       <= '0;
                end else begin
                    r_blk <= n_blk;
                    r_pos <= r_pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_job_valid && !i_job_ready) begin
            assert (o_full || !(i_push && ((r_pos == 4'd15) || i_in.last_byte)))
                else $error("front issued over a waiting job");
        end
    end

    property p_pos_clear;
        @(posedge i_clk) disable iff (!i_rst_n) w_issue |=> (r_pos == 4'd0);
    endproperty
    a_pos_clear: assert property (p_pos_clear) else $error("byte position not cleared");

    property p_job_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_job_valid && !i_job_ready) |=> (r_job_valid && $stable(r_job));
    endproperty
    a_job_hold: assert property (p_job_hold) else $error("job dropped while stalled");

    property p_blk_zero;
        @(posedge i_clk) disable iff (!i_rst_n) w_issue |=> (r_blk == '0);
    endproperty
    a_blk_zero: assert property (p_blk_zero) else $error("block not cleared after issue");

endmodule

FILE: hdl/acmt_back.sv
// Back end: iterative AES-128 over a job queue, chaining state, tag output register.
module acmt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  acmt_pkg::t_job   i_job,
    output logic             o_job_ready,
    input  logic [127:0]     i_key,
    output logic             o_empty,
    input  logic             i_pop,
    output acmt_pkg::t_out_beat o_out
);
    import acmt_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_job         r_q [QueueDepth];
    logic [1:0]   r_cnt;
    logic         r_rd, r_wr;
    t_state       r_state;
    logic [127:0] r_chain, r_s, r_rk;
    logic [7:0]   r_rc;
    logic [3:0]   r_rnd;
    logic         r_last;
    logic         r_out_valid;
    t_out_beat    r_out;
    logic [127:0] w_rk_next, w_s_next;
    logic         w_push, w_start, w_done;

    assign o_job_ready = (r_cnt != 2'(QueueDepth));
    assign w_push  = i_job_valid && o_job_ready;
    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

    assign w_rk_next = key_step(r_rk, r_rc);
    assign w_s_next  = aes_round(r_s, w_rk_next, r_rnd == 4'(Rounds));
    // A message-closing job holds in its final round until the tag register is free.
    assign w_done    = (r_state == ST_RUN) && (r_rnd == 4'(Rounds)) &&
                       !(r_last && r_out_valid && !i_pop);
    assign w_start = (r_state == ST_IDLE || w_done) && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_rd        <= 1'b0;
            r_wr        <= 1'b0;
            r_state     <= ST_IDLE;
            r_chain     <= '0;
            r_out_valid <= 1'b0;
            r_rnd       <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_start);
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_done && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (w_done) begin
                if (r_last) begin
                    r_out.tag_high <= w_s_next[127:64];
                    r_out.tag_low  <= w_s_next[63:0];
                    r_chain       <= '0;
                end else begin
                    r_chain <= w_s_next;
                end
                if (!w_start) begin
                    r_state <= ST_IDLE;
                end
            end else if (r_state == ST_RUN && r_rnd != 4'(Rounds)) begin
                r_s   <= w_s_next;
                r_rk  <= w_rk_next;
                r_rc  <= next_rcon(r_rc);
                r_rnd <= r_rnd + 4'd1;
            end
            if (w_start) begin
                r_rd    <= !r_rd;
                r_state <= ST_RUN;
                r_rnd   <= 4'd1;
                r_rc    <= 8'h01;
                r_rk    <= i_key;
                r_last  <= r_q[r_rd].last;
                r_s     <= r_q[r_rd].block ^ i_key ^
                           ((w_done && !r_last) ? w_s_next : (w_done ? '0 : r_chain));
            end
        end
    end

    property p_no_overwrite;
        @(posedge i_clk) disable iff (!i_rst_n)
            (w_done && r_last) |-> (!r_out_valid || i_pop);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite) else $error("tag overwritten");

    property p_cnt_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QueueDepth);
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("job queue overflow");

    property p_rounds;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_RUN) |-> (r_rnd >= 4'd1 && r_rnd <= 4'(Rounds));
    endproperty
    a_rounds: assert property (p_rounds) else $error("round count out of range");

endmodule

FILE: hdl/aes_cbc_mac_tag.sv
// Top level of the AES-128 CBC-MAC tag engine.
// Usage:
//   Input channel: one message byte per beat (push/full); last_byte marks the
//   final byte. Bytes may arrive every cycle with no gaps while full is low.
//   Result channel: one 128-bit tag per message (empty/pop); the tag is held
//   on the ports until popped.
//   Config channel: valid/ready write of key_high (index 0) or key_low
//   (index 1); always ready. Write only while the block is idle.
//   Throughput: one byte per cycle while full is low. Each 16-byte block (or the
//   final partial block) is encrypted by a single shared round unit with an
//   on-the-fly key schedule, well inside the 16 byte arrivals of a block.
//   The last block passes from the front's job register via the job queue
//   and the round unit into the result register. Messages shorter than about
//   10 bytes back to back may see full raised; each needs a whole encryption.
//   When the receiver stalls, the finished tag waits in the output register,
//   the next message's blocks queue up (two deep) and full rises after that.
//   Reset: synchronous, active low; clears chain state, byte position and key
//   registers, empties the job queue and the result register. No clearing pass.
module aes_cbc_mac_tag (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  acmt_pkg::t_in_beat     i_in,
    output logic                   empty,
    input  logic                   pop,
    output acmt_pkg::t_out_beat    o_out,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [63:0]            i_cfg_data
);
    import acmt_pkg::*;

    logic [63:0] r_key_high, r_key_low;
    logic        w_job_valid, w_job_ready;
    t_job        w_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_index'(i_cfg_index))
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      r_key_low  <= r_key_low;
            endcase
        end
    end

    acmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in        (i_in),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_ready (w_job_ready)
    );

    acmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_ready (w_job_ready),
        .i_key       ({r_key_high, r_key_low}),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

endmodule

FILE: bench/tb.sv
// Testbench for aes_cbc_mac_tag: directed and random messages checked against an AES CBC-MAC predictor.
`timescale 1ns / 100ps

module tb;
    import acmt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_beat    i_in;
    logic        empty;
    logic        pop;
    t_out_beat   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    aes_cbc_mac_tag DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_in(i_in),
        .empty(empty), .pop(pop), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    typedef struct {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        known;
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } t_row;

    logic [127:0] mac_key;
    logic [127:0] mac_chain;
    logic [3:0]   mac_pos;
    t_out_beat    tag_fifo[$];
    int           errors;
    int           tags_seen;
    int           bytes_sent;
    int           send_idle;
    int           recv_idle;

    localparam logic [7:0] RoundConst [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                               8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt, input logic [127:0] key);
        logic [7:0]   rk [176];
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   w0, w1, w2, w3, tt, al;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        end
        for (int i = 16; i < 176; i += 4) begin
            w0 = rk[i - 4]; w1 = rk[i - 3]; w2 = rk[i - 2]; w3 = rk[i - 1];
            if ((i % 16) == 0) begin
                tt = w0;
                w0 = Sbox[w1] ^ RoundConst[i / 16 - 1];
                w1 = Sbox[w2];
                w2 = Sbox[w3];
                w3 = Sbox[tt];
            end
            rk[i] = rk[i - 16] ^ w0;
            rk[i + 1] = rk[i - 15] ^ w1;
            rk[i + 2] = rk[i - 14] ^ w2;
            rk[i + 3] = rk[i - 13] ^ w3;
        end
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) begin
                    sh[i + 4 * c] = Sbox[st[i + 4 * ((c + i) % 4)]];
                end
            end
            for (int c = 0; c < 4; c++) begin
                if (r != 10) begin
                    al = sh[4*c] ^ sh[4*c+1] ^ sh[4*c+2] ^ sh[4*c+3];
                    st[4*c]   = sh[4*c]   ^ al ^ xtime(sh[4*c]   ^ sh[4*c+1]);
                    st[4*c+1] = sh[4*c+1] ^ al ^ xtime(sh[4*c+1] ^ sh[4*c+2]);
                    st[4*c+2] = sh[4*c+2] ^ al ^ xtime(sh[4*c+2] ^ sh[4*c+3]);
                    st[4*c+3] = sh[4*c+3] ^ al ^ xtime(sh[4*c+3] ^ sh[4*c]);
                end else begin
                    for (int i = 0; i < 4; i++) st[4*c+i] = sh[4*c+i];
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[16 * r + i];
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    // absorb one byte; returns 1 with the tag when the message closes
    function automatic bit mac_absorb(input t_in_beat b, output t_out_beat tag);
        mac_chain[127 - 8 * mac_pos -: 8] ^= b.data_byte;
        mac_pos++;
        if (mac_pos == 0) mac_chain = aes_encrypt(mac_chain, mac_key);
        if (!b.last_byte) return 0;
        if (mac_pos != 0) mac_chain = aes_encrypt(mac_chain, mac_key);
        tag = mac_chain;
        mac_chain = '0;
        mac_pos = '0;
        return 1;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("aes_cbc_mac_tag test failed");
        $finish;
    end

    // push stays high between back-to-back beats; drain drops it
    task automatic drive_beat(input t_in_beat b);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_beat(input t_in_beat b);
        t_out_beat tag;
        drive_beat(b);
        if (mac_absorb(b, tag)) tag_fifo.push_back(tag);
    endtask

    task automatic write_key(input t_reg_index idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_KEY_HIGH) mac_key[127:64] = val;
        else mac_key[63:0] = val;
        @(posedge i_clk);
    endtask

    task automatic drain;
        push <= 1'b0;
        while (tag_fifo.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_message(input int len);
        t_in_beat b;
        for (int k = 0; k < len; k++) begin
            b.data_byte = $urandom_range(255);
            b.last_byte = (k == len - 1);
            send_beat(b);
        end
    endtask

    // receiver: check each popped tag against the oldest prediction
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && pop && !empty) begin
            tags_seen++;
            if (tag_fifo.size() == 0) begin
                $error("tag popped with none expected");
                errors++;
            end else begin
                want = tag_fifo.pop_front();
                if (o_out.tag_high !== want.tag_high) begin
                    $error("tag_high exp %h got %h", want.tag_high, o_out.tag_high);
                    errors++;
                end
                if (o_out.tag_low !== want.tag_low) begin
                    $error("tag_low exp %h got %h", want.tag_low, o_out.tag_low);
                    errors++;
                end
            end
        end
        pop <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    t_row rows [] = '{
        '{8'h00, 1'b1, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
        '{8'hff, 1'b0, 1'b0, '0, '0}, '{8'h80, 1'b0, 1'b0, '0, '0},
        '{8'h01, 1'b0, 1'b0, '0, '0}, '{8'h7f, 1'b1, 1'b0, '0, '0},
        '{8'h00, 1'b0, 1'b0, '0, '0}, '{8'h00, 1'b0, 1'b0, '0, '0},
        '{8'h00, 1'b0, 1'b0, '0, '0}, '{8'h00, 1'b0, 1'b0, '0, '0},
        '{8'h00, 1'b0, 1'b0, '0, '0}, '{8'h00, 1'b0, 1'b0, '0, '0},
        '{8'h00, 1'b0, 1'b0, '0, '0}, '{8'h00, 1'b0, 1'b0, '0, '0},
        '{8'h00, 1'b0, 1'b0, '0, '0}, '{8'h00, 1'b0, 1'b0, '0, '0},
        '{8'h00, 1'b0, 1'b0, '0, '0}, '{8'h00, 1'b0, 1'b0, '0, '0},
        '{8'h00, 1'b0, 1'b0, '0, '0}, '{8'h00, 1'b0, 1'b0, '0, '0},
        '{8'h00, 1'b0, 1'b0, '0, '0}, '{8'h00, 1'b1, 1'b0, '0, '0},
        '{8'hff, 1'b1, 1'b0, '0, '0}
    };

    initial begin
        t_in_beat  b;
        t_out_beat tag;
        int        msgs;
        errors = 0; tags_seen = 0; bytes_sent = 0;
        send_idle = 0; recv_idle = 0;
        mac_key = '0; mac_chain = '0; mac_pos = '0;
        i_rst_n = 0; push = 0; i_in = '0;
        i_cfg_valid = 0; i_cfg_index = REG_KEY_HIGH; i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero key, all-zero block has a well known tag
        foreach (rows[n]) begin
            b.data_byte = rows[n].data_byte;
            b.last_byte = rows[n].last_byte;
            if (rows[n].known) begin
                void'(mac_absorb(b, tag));
                tag_fifo.push_back({rows[n].tag_high, rows[n].tag_low});
                drive_beat(b);
            end else begin
                send_beat(b);
            end
        end
        drain();
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        random_message(16);
        random_message(33);
        drain();

        msgs = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 13 : (ph == 1) ? 63 : 0;
            recv_idle = (ph == 0) ? 63 : (ph == 1) ? 13 : 0;
            for (int k = 0; k < 4; k++) begin
                drain();
                write_key(REG_KEY_HIGH, {$urandom, $urandom});
                write_key(REG_KEY_LOW, (k == 3) ? 64'h0 : {$urandom, $urandom});
                for (int m = 0; m < 7; m++) begin
                    case ($urandom_range(3))
                        0: random_message($urandom_range(1, 4));
                        1: random_message(16 * $urandom_range(1, 2));
                        default: random_message($urandom_range(1, 40));
                    endcase
                    msgs++;
                end
            end
        end
        send_idle = 0;
        drain();

        $display("Sent %0d bytes, checked %0d tags across %0d random messages.",
                 bytes_sent, tags_seen, msgs);
        $display("Covered three idle profiles, multiple keys incl. all-ones and partial-zero.");
        if (errors == 0 && tag_fifo.size() == 0) begin
            $display("aes_cbc_mac_tag test passed");
        end else begin
            $display("aes_cbc_mac_tag test failed");
        end
        $finish;
    end
endmodule
